>>> rtl/core/bsefn_pkg.sv
// ----------------------------------------------------------------------------
// Bitset engine package
// Shared widths, opcodes, default sizes and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package bsefn_pkg;

    localparam int WORD_BITS    = 32;
    localparam int DEF_NUM_SETS = 8;
    localparam int DEF_MAX_BITS = 1024;

    localparam int OP_W   = 4;
    localparam int SET_W  = 3;
    localparam int IDX_W  = 11;
    localparam int LEN_W  = 11;
    // Word counter: holds up to 2**(LEN_W-5) words per set.
    localparam int WCNT_W = LEN_W - 4;

    localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

    localparam logic REG_BIT_LENGTH = 1'b0;

    localparam logic [OP_W-1:0] OP_SET    = 4'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 4'd1;
    localparam logic [OP_W-1:0] OP_READ   = 4'd2;
    localparam logic [OP_W-1:0] OP_AND    = 4'd3;
    localparam logic [OP_W-1:0] OP_OR     = 4'd4;
    localparam logic [OP_W-1:0] OP_INVERT = 4'd5;
    localparam logic [OP_W-1:0] OP_NEXT   = 4'd6;
    localparam logic [OP_W-1:0] OP_ZERO   = 4'd7;
    localparam logic [OP_W-1:0] OP_COPY   = 4'd8;

    typedef struct packed {
        logic clr_we;
        logic accept;
        logic issue;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic issue_done;
        logic pend;
        logic found;
    } t_dp_sts;

endpackage

>>> rtl/core/bsefn_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module bsefn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    output logic [WIDTH-1:0] o_rdata_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

>>> rtl/core/bsefn_ctrl.sv
// ----------------------------------------------------------------------------
// Bitset engine controller
// Sequences the reset clearing sweep, request acceptance, the word walk
// and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module bsefn_ctrl
    import bsefn_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_WALK  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.issue = !i_sts.issue_done && !i_sts.found;
                if (i_sts.found || i_sts.issue_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // A hit ends the walk, so no further word read may start with it.
    a_no_issue_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.found |-> !o_cmd.issue)
        else $error("word read issued in the cycle of a search hit");

    // A new request is only taken when no word read is in flight.
    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |-> !i_sts.pend)
        else $error("request accepted with a word read in flight");

    // A loaded result is presented in the following cycle.
    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid)
        else $error("loaded result not presented");

endmodule

>>> rtl/core/bsefn_dp.sv
// ----------------------------------------------------------------------------
// Bitset engine datapath
// Decodes a request, walks the words of the target set through the
// bitset RAM one word per cycle, and builds the result.
// ----------------------------------------------------------------------------
module bsefn_dp
    import bsefn_pkg::*;
#(
    parameter int NUM_SETS = DEF_NUM_SETS,
    parameter int MAX_BITS = DEF_MAX_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_sts          o_sts,
    input  logic [LEN_W-1:0] i_bit_length,
    input  logic [OP_W-1:0]  i_opcode,
    input  logic [SET_W-1:0] i_target_set,
    input  logic [SET_W-1:0] i_other_set,
    input  logic [IDX_W-1:0] i_bit_index,
    output logic             o_bit_value,
    output logic [IDX_W-1:0] o_next_index,
    output logic             o_bad_request
);

    localparam int WPS    = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH  = NUM_SETS * WPS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [LEN_W-1:0] MAX_LEN =
        (MAX_BITS >= (1 << LEN_W)) ? {LEN_W{1'b1}} : LEN_W'(MAX_BITS);

    function automatic logic [4:0] f_low_bit(input logic [WORD_BITS-1:0] w);
        logic [WORD_BITS-1:0] v;
        logic [4:0]           p;
        v = w;
        p = '0;
        for (int k = 4; k >= 0; k--) begin
            if ((v & ((32'd1 << (1 << k)) - 32'd1)) == '0) begin
                p[k] = 1'b1;
                v    = v >> (1 << k);
            end
        end
        return p;
    endfunction

    logic [LEN_W-1:0]     len;
    logic [LEN_W:0]       len_up;
    logic [WCNT_W-1:0]    nw;
    logic [IDX_W-1:0]     first;
    logic                 a_bad;
    logic [WCNT_W-1:0]    a_start;
    logic [WCNT_W-1:0]    a_limit;

    logic [OP_W-1:0]      r_op;
    logic [SET_W-1:0]     r_tgt;
    logic [SET_W-1:0]     r_oth;
    logic [4:0]           r_bitpos;
    logic [IDX_W-1:0]     r_first;
    logic [WCNT_W-1:0]    r_word;
    logic [WCNT_W-1:0]    r_limit;
    logic                 r_pend;
    logic [WCNT_W-1:0]    r_pend_word;
    logic                 r_bad;
    logic                 r_bitv;
    logic [IDX_W-1:0]     r_nxt;
    logic [ADDR_W-1:0]    r_clr;
    logic                 r_out_bitv;
    logic [IDX_W-1:0]     r_out_nxt;
    logic                 r_out_bad;

    logic [WORD_BITS-1:0] rd_a;
    logic [WORD_BITS-1:0] rd_b;
    logic [WORD_BITS-1:0] srch_word;
    logic [IDX_W-1:0]     pos;
    logic                 found;
    logic                 wr_op;
    logic [WORD_BITS-1:0] wr_data;
    logic [ADDR_W-1:0]    addr_a;
    logic [ADDR_W-1:0]    addr_b;
    logic [ADDR_W-1:0]    addr_w;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;

    assign len    = (i_bit_length > MAX_LEN) ? MAX_LEN : i_bit_length;
    assign len_up = {1'b0, len} + (LEN_W + 1)'(WORD_BITS - 1);
    assign nw     = len_up[LEN_W:5];
    assign first  = i_bit_index + IDX_W'(1);

    always_comb begin
        a_bad   = (32'(i_target_set) >= 32'(NUM_SETS));
        a_start = '0;
        a_limit = nw;
        unique case (i_opcode) inside
            OP_SET, OP_CLEAR, OP_READ: begin
                if (i_bit_index[IDX_W-1] || (i_bit_index >= len)) begin
                    a_bad = 1'b1;
                end
                a_start = WCNT_W'(i_bit_index[IDX_W-2:5]);
                a_limit = a_start + WCNT_W'(1);
            end
            OP_AND, OP_OR, OP_COPY: begin
                if (32'(i_other_set) >= 32'(NUM_SETS)) begin
                    a_bad = 1'b1;
                end
            end
            OP_INVERT, OP_ZERO: begin
                a_limit = nw;
            end
            OP_NEXT: begin
                if (i_bit_index[IDX_W-1] && (i_bit_index != {IDX_W{1'b1}})) begin
                    a_bad = 1'b1;
                end
                if (!i_bit_index[IDX_W-1] && (i_bit_index >= len)) begin
                    a_bad = 1'b1;
                end
                a_start = WCNT_W'(first[IDX_W-1:5]);
            end
            default: begin
                a_bad = 1'b1;
            end
        endcase
        if (a_bad) begin
            a_start = '0;
            a_limit = '0;
        end
    end

    assign addr_a = (ADDR_W'(r_tgt) * ADDR_W'(WPS)) + ADDR_W'(r_word);
    assign addr_b = (ADDR_W'(r_oth) * ADDR_W'(WPS)) + ADDR_W'(r_word);
    assign addr_w = (ADDR_W'(r_tgt) * ADDR_W'(WPS)) + ADDR_W'(r_pend_word);

    assign srch_word = (r_pend_word == WCNT_W'(r_first[IDX_W-1:5]))
                     ? (rd_a & ({WORD_BITS{1'b1}} << r_first[4:0])) : rd_a;
    assign found     = r_pend && (r_op == OP_NEXT) && (srch_word != '0);
    assign pos       = {r_pend_word[WCNT_W-2:0], f_low_bit(srch_word)};

    always_comb begin
        wr_op   = 1'b0;
        wr_data = rd_a;
        case (r_op)
            OP_SET: begin
                wr_op   = r_pend;
                wr_data = rd_a | (WORD_BITS'(1) << r_bitpos);
            end
            OP_CLEAR: begin
                wr_op   = r_pend;
                wr_data = rd_a & ~(WORD_BITS'(1) << r_bitpos);
            end
            OP_AND: begin
                wr_op   = r_pend;
                wr_data = rd_a & rd_b;
            end
            OP_OR: begin
                wr_op   = r_pend;
                wr_data = rd_a | rd_b;
            end
            OP_INVERT: begin
                wr_op   = r_pend;
                wr_data = ~rd_a;
            end
            OP_ZERO: begin
                wr_op   = r_pend;
                wr_data = '0;
            end
            OP_COPY: begin
                wr_op   = r_pend;
                wr_data = rd_b;
            end
            default: begin
                wr_op   = 1'b0;
                wr_data = rd_a;
            end
        endcase
    end

    assign ram_we    = i_cmd.clr_we || wr_op;
    assign ram_waddr = i_cmd.clr_we ? r_clr : addr_w;
    assign ram_wdata = i_cmd.clr_we ? '0 : wr_data;

    bsefn_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (ram_wdata),
        .i_raddr_a (addr_a),
        .o_rdata_a (rd_a),
        .i_raddr_b (addr_b),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word  <= '0;
            r_limit <= '0;
            r_pend  <= 1'b0;
            r_bad   <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_pend <= i_cmd.issue;
            if (i_cmd.accept) begin
                r_word  <= a_start;
                r_limit <= a_limit;
                r_bad   <= a_bad;
            end else if (i_cmd.issue) begin
                r_word <= r_word + WCNT_W'(1);
            end
            if (i_cmd.clr_we) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= i_opcode;
            r_tgt    <= i_target_set;
            r_oth    <= i_other_set;
            r_bitpos <= i_bit_index[4:0];
            r_first  <= first;
            r_bitv   <= 1'b0;
            r_nxt    <= {IDX_W{1'b1}};
        end else begin
            if (r_pend && (r_op == OP_READ)) begin
                r_bitv <= rd_a[r_bitpos];
            end
            if (found && (pos < len)) begin
                r_nxt <= pos;
            end
        end
        if (i_cmd.issue) begin
            r_pend_word <= r_word;
        end
        if (i_cmd.load_out) begin
            r_out_bitv <= r_bitv;
            r_out_nxt  <= r_nxt;
            r_out_bad  <= r_bad;
        end
    end

    assign o_sts.clr_last   = (r_clr == ADDR_W'(DEPTH - 1));
    assign o_sts.issue_done = (r_word >= r_limit);
    assign o_sts.pend       = r_pend;
    assign o_sts.found      = found;

    assign o_bit_value   = r_out_bitv;
    assign o_next_index  = r_out_nxt;
    assign o_bad_request = r_out_bad;

    // A refused request must leave the store untouched.
    a_bad_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_bad && wr_op))
        else $error("refused request wrote the bitset store");

    // The walk never runs past its word limit.
    a_word_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word <= r_limit)
        else $error("word counter beyond its limit");

    // Returning read data always belongs to a word below the limit.
    a_pend_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_pend_word < r_limit))
        else $error("read data for a word outside the walk");

endmodule

>>> rtl/core/bitset_engine_find_next_top.sv
// ----------------------------------------------------------------------------
// Bitset engine with find-next-set-bit
// Holds NUM_SETS bitsets in a word RAM and serves set, clear, read, and,
// or, invert, zero, copy and next-set-bit requests, one result each.
//
// Requests enter on the input channel (i_in_valid / o_in_stall) and each
// gives one result on the output channel (o_out_valid / i_out_stall).
// The engine works on one request at a time and steps through the RAM one
// 32-bit word per cycle. A single-bit request walks one word, a refused
// request none, a whole-set request the words that bit_length covers (32
// at the default length), and a search those from its start index on; a
// search stops at its first hit. The result is registered; the done state
// loads it into the output register once that register is free.
// While a result waits on i_out_stall, the next request is still taken and
// processed; it finishes when the output register frees.
// After reset every word of the RAM (256 by default) is cleared, one word
// per cycle, with o_in_stall high. bit_length is set through the APB port
// at byte address 0 and resets to 1024.
// ----------------------------------------------------------------------------
module bitset_engine_find_next_top
    import bsefn_pkg::*;
#(
    parameter int NUM_SETS = DEF_NUM_SETS,
    parameter int MAX_BITS = DEF_MAX_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic [SET_W-1:0]        i_target_set,
    input  logic [SET_W-1:0]        i_other_set,
    input  logic signed [IDX_W-1:0] i_bit_index,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic                    o_bit_value,
    output logic signed [IDX_W-1:0] o_next_index,
    output logic                    o_bad_request
);

    logic [LEN_W-1:0] r_bit_length;
    t_dp_cmd          cmd;
    t_dp_sts          sts;
    logic [IDX_W-1:0] next_index;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_length <= LEN_RESET;
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_BIT_LENGTH)) begin
            r_bit_length <= pwdata[LEN_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_BIT_LENGTH) ? {{(32 - LEN_W){1'b0}}, r_bit_length}
                                                  : 32'd0;

    bsefn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    bsefn_dp #(
        .NUM_SETS (NUM_SETS),
        .MAX_BITS (MAX_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_bit_length  (r_bit_length),
        .i_opcode      (i_opcode),
        .i_target_set  (i_target_set),
        .i_other_set   (i_other_set),
        .i_bit_index   ($unsigned(i_bit_index)),
        .o_bit_value   (o_bit_value),
        .o_next_index  (next_index),
        .o_bad_request (o_bad_request)
    );

    assign o_next_index = $signed(next_index);

endmodule
